>>> design/iirdf_pkg.sv
// ----------------------------------------------------------------------------
// IIR direct-form filter package
// Shared constants, request codes, sequencer states and divider bundles.
// ----------------------------------------------------------------------------
package iirdf_pkg;

  localparam int MAX_ORDER_DEF    = 10;
  localparam int COEF_WIDTH_DEF   = 16;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int ACC_W   = 32;
  localparam int FILT_W  = 26;
  localparam int REQ_W   = 2;
  localparam int IDX_W   = 4;
  localparam int ORDER_W = 4;

  localparam logic [ORDER_W-1:0] ORDER_RST = 4'd4;
  localparam logic [ACC_W-1:0]   SCALE     = 32'd100;

  // floor(m / 100) == (m * SCALE_RECIP) >> SCALE_SHIFT for every 32-bit m.
  localparam logic [ACC_W-1:0]   SCALE_RECIP = 32'h51EB_851F;
  localparam int                 SCALE_SHIFT = 37;

  typedef enum logic [REQ_W-1:0] {
    REQ_FILTER = 2'd0,
    REQ_NUM    = 2'd1,
    REQ_DEN    = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_CW   = 8'b0000_0010,
    ST_A0   = 8'b0000_0100,
    ST_MUL  = 8'b0000_1000,
    ST_SUB  = 8'b0001_0000,
    ST_DIV  = 8'b0010_0000,
    ST_FIN  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] num;
    logic [ACC_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] quo;
  } div_rsp_t;

endpackage

>>> design/iir_direct_form_filter.sv
// ----------------------------------------------------------------------------
// IIR direct-form-I filter, top level
// A sample with n taps in use (order clamped to MAX_ORDER) is worked as n+1
// terms, each a multiply, a divider start and a run of the shared bit-serial
// divider; state FIN then scales the sum by 100. A zero a0 skips the terms
// and goes straight to state OUT; a coefficient write passes through state CW.
// One item is in work at a time: in_ready is high only in the idle state.
// Reset is synchronous: order returns to 4, tables read as zero via valid bits.
// ----------------------------------------------------------------------------
module iir_direct_form_filter #(
  parameter int MAX_ORDER    = iirdf_pkg::MAX_ORDER_DEF,
  parameter int COEF_WIDTH   = iirdf_pkg::COEF_WIDTH_DEF,
  parameter int SAMPLE_WIDTH = iirdf_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [iirdf_pkg::ORDER_W-1:0]     cfg_filter_order,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [iirdf_pkg::REQ_W-1:0]       in_req_type,
  input  logic [iirdf_pkg::IDX_W-1:0]       in_coef_index,
  input  logic signed [COEF_WIDTH-1:0]      in_coef_value,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [iirdf_pkg::FILT_W-1:0] out_filtered,
  output logic                              out_divide_fault
);

  localparam int W    = iirdf_pkg::ACC_W;
  localparam int PW   = 2 * W;
  localparam int CD   = MAX_ORDER + 1;
  localparam int CAW  = $clog2(CD);
  localparam int HAW  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CW2  = 2 * COEF_WIDTH;
  localparam int HW   = SAMPLE_WIDTH + W;

  iirdf_pkg::state_t state_r, state_nxt;

  logic [iirdf_pkg::ORDER_W-1:0] order_r;
  logic [CAW-1:0]                n_r;
  logic [HAW-1:0]                k_r;
  logic                          more_r;
  logic [W-1:0]                  acc_r, acc_nxt;
  logic [W-1:0]                  a0_r;
  logic [W-1:0]                  x_r;
  logic [SAMPLE_WIDTH-1:0]       xs_r;
  logic [W-1:0]                  pb_r, pa_r;
  logic [iirdf_pkg::REQ_W-1:0]   req_r;
  logic [CAW-1:0]                cidx_r;
  logic [COEF_WIDTH-1:0]         cval_r;
  logic [iirdf_pkg::FILT_W-1:0]  res_r;
  logic                          sneg_r;
  logic                          fault_r;
  logic                          out_valid_r;
  logic [iirdf_pkg::FILT_W-1:0]  out_filt_r;
  logic                          out_fault_r;

  logic                          coef_vld_r [CD];
  logic                          hist_vld_r [MAX_ORDER];
  logic                          crd_vld_r;
  logic                          hrd_vld_r;

  logic                          coef_we;
  logic [CAW-1:0]                coef_raddr;
  logic [CW2-1:0]                coef_wdata, coef_rdata, coef_q;
  logic                          hist_we;
  logic [HAW-1:0]                hist_waddr;
  logic [HW-1:0]                 hist_wdata, hist_rdata, hist_q;

  logic [COEF_WIDTH-1:0]         b_c, a_c;
  logic [W-1:0]                  b_s, a_s, xh_s, yh_s;
  logic [CAW-1:0]                k_next;
  logic                          accept;
  logic                          idx_ok;
  logic [W-1:0]                  mag_s;
  logic [PW-1:0]                 prod_s;

  iirdf_pkg::div_req_t div_req;
  iirdf_pkg::div_rsp_t div_rsp;

  assign in_ready = (state_r == iirdf_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign idx_ok   = (int'(in_coef_index) <= MAX_ORDER);

  // Entries never written read as zero.
  assign coef_q = crd_vld_r ? coef_rdata : '0;
  assign hist_q = hrd_vld_r ? hist_rdata : '0;
  assign b_c    = coef_q[CW2-1:COEF_WIDTH];
  assign a_c    = coef_q[COEF_WIDTH-1:0];
  assign b_s    = W'($signed(b_c));
  assign a_s    = W'($signed(a_c));
  assign xh_s   = W'($signed(hist_q[HW-1:W]));
  assign yh_s   = hist_q[W-1:0];
  assign k_next = CAW'(k_r) + 1'b1;

  // Output scaling works on the magnitude so the quotient truncates toward zero.
  assign mag_s  = acc_r[W-1] ? W'(-acc_r) : acc_r;
  assign prod_s = PW'(mag_s) * PW'(iirdf_pkg::SCALE_RECIP);

  assign coef_raddr = (state_r == iirdf_pkg::ST_IDLE) ?
                      ((in_req_type == iirdf_pkg::REQ_FILTER) ? '0
                                                              : CAW'(in_coef_index))
                      : k_next;

  assign acc_nxt = acc_r + div_rsp.quo;

  always_comb begin
    coef_we    = 1'b0;
    coef_wdata = (req_r == iirdf_pkg::REQ_NUM) ? {cval_r, a_c} : {b_c, cval_r};
    hist_we    = 1'b0;
    hist_waddr = HAW'(k_next);
    hist_wdata = hist_q;
    div_req    = '{start: 1'b0, num: W'(pb_r - pa_r), den: a0_r};
    state_nxt  = state_r;
    case (state_r)
      iirdf_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_req_type == iirdf_pkg::REQ_FILTER) begin
            state_nxt = iirdf_pkg::ST_A0;
          end else if ((in_req_type == iirdf_pkg::REQ_NUM ||
                        in_req_type == iirdf_pkg::REQ_DEN) && idx_ok) begin
            state_nxt = iirdf_pkg::ST_CW;
          end
        end
      end
      iirdf_pkg::ST_CW: begin
        coef_we   = 1'b1;
        state_nxt = iirdf_pkg::ST_IDLE;
      end
      iirdf_pkg::ST_A0: begin
        state_nxt = (a_c == '0) ? iirdf_pkg::ST_OUT : iirdf_pkg::ST_SUB;
      end
      iirdf_pkg::ST_MUL: begin
        // Shift this slot up by one while its old value is consumed.
        hist_we   = (k_next < n_r);
        state_nxt = iirdf_pkg::ST_SUB;
      end
      iirdf_pkg::ST_SUB: begin
        div_req.start = 1'b1;
        state_nxt     = iirdf_pkg::ST_DIV;
      end
      iirdf_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          if (more_r) begin
            state_nxt = iirdf_pkg::ST_MUL;
          end else begin
            hist_we    = 1'b1;
            hist_waddr = '0;
            hist_wdata = {xs_r, acc_nxt};
            state_nxt  = iirdf_pkg::ST_FIN;
          end
        end
      end
      iirdf_pkg::ST_FIN: begin
        state_nxt = iirdf_pkg::ST_OUT;
      end
      iirdf_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = iirdf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = iirdf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iirdf_pkg::ST_IDLE;
      order_r     <= iirdf_pkg::ORDER_RST;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CD; i++) begin
        coef_vld_r[i] <= 1'b0;
      end
      for (int i = 0; i < MAX_ORDER; i++) begin
        hist_vld_r[i] <= 1'b0;
      end
      crd_vld_r <= 1'b0;
      hrd_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      crd_vld_r <= coef_vld_r[coef_raddr];
      hrd_vld_r <= hist_vld_r[k_r];
      if (cfg_we) begin
        order_r <= cfg_filter_order;
      end
      if (coef_we) begin
        coef_vld_r[cidx_r] <= 1'b1;
      end
      if (hist_we) begin
        hist_vld_r[hist_waddr] <= 1'b1;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == iirdf_pkg::ST_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      iirdf_pkg::ST_IDLE: begin
        req_r  <= in_req_type;
        cidx_r <= CAW'(in_coef_index);
        cval_r <= in_coef_value;
        xs_r   <= in_sample;
        x_r    <= W'(in_sample);
        if (int'(order_r) > MAX_ORDER) begin
          n_r <= CAW'(MAX_ORDER);
        end else begin
          n_r <= CAW'(order_r);
        end
      end
      iirdf_pkg::ST_A0: begin
        a0_r    <= a_s;
        pb_r    <= W'(x_r * b_s);
        pa_r    <= '0;
        acc_r   <= '0;
        res_r   <= '0;
        sneg_r  <= 1'b0;
        fault_r <= (a_c == '0);
        more_r  <= (n_r != '0);
        k_r     <= HAW'(n_r - 1'b1);
      end
      iirdf_pkg::ST_MUL: begin
        pb_r <= W'(b_s * xh_s);
        pa_r <= W'(a_s * yh_s);
        if (k_r == '0) begin
          more_r <= 1'b0;
        end else begin
          k_r <= k_r - 1'b1;
        end
      end
      iirdf_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          acc_r <= acc_nxt;
        end
      end
      iirdf_pkg::ST_FIN: begin
        res_r  <= prod_s[iirdf_pkg::SCALE_SHIFT +: iirdf_pkg::FILT_W];
        sneg_r <= acc_r[W-1];
      end
      iirdf_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_filt_r  <= sneg_r ? (-res_r) : res_r;
          out_fault_r <= fault_r;
        end
      end
      default: ;
    endcase
  end

  iirdf_ram #(.WIDTH(CW2), .DEPTH(CD), .AW(CAW)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (cidx_r),
    .wdata (coef_wdata),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  iirdf_ram #(.WIDTH(HW), .DEPTH(MAX_ORDER), .AW(HAW)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (k_r),
    .rdata (hist_rdata)
  );

  iirdf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_valid        = out_valid_r;
  assign out_filtered     = out_filt_r;
  assign out_divide_fault = out_fault_r;

endmodule

>>> design/iirdf_ram.sv
// ----------------------------------------------------------------------------
// IIR filter RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module iirdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/iirdf_div.sv
// ----------------------------------------------------------------------------
// IIR filter divider
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating
// toward zero. The quotient wraps, so the most negative value over -1
// returns itself.
// ----------------------------------------------------------------------------
module iirdf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  iirdf_pkg::div_req_t req,
  output iirdf_pkg::div_rsp_t rsp
);

  localparam int W = iirdf_pkg::ACC_W;

  logic [W-1:0]         q_r, q_nxt;
  logic [W-1:0]         rem_r, rem_nxt;
  logic [W-1:0]         md_r;
  logic                 neg_r;
  logic                 busy_r;
  logic                 done_r;
  logic [$clog2(W)-1:0] cnt_r;
  logic [W:0]           sh;
  logic                 ge;

  always_comb begin
    sh      = {rem_r, q_r[W-1]};
    ge      = (sh >= {1'b0, md_r});
    rem_nxt = ge ? W'(sh - {1'b0, md_r}) : sh[W-1:0];
    q_nxt   = {q_r[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (&cnt_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end else if (req.start) begin
      q_r   <= req.num[W-1] ? W'(-req.num) : req.num;
      md_r  <= req.den[W-1] ? W'(-req.den) : req.den;
      neg_r <= req.num[W-1] ^ req.den[W-1];
      rem_r <= '0;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = neg_r ? W'(-q_r) : q_r;

endmodule

>>> dv/tb_iir_direct_form_filter.sv
// ----------------------------------------------------------------------------
// IIR direct-form-I filter testbench
// Sends coefficient writes and samples through a valid/ready driver. A
// scoreboard model computes each expected output and the divide fault, and a
// monitor compares them with what the filter returns, under random stalls.
// ----------------------------------------------------------------------------
module tb_iir_direct_form_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTAPS = iirdf_pkg::MAX_ORDER_DEF;

  typedef struct packed {
    iirdf_pkg::req_t req;
    logic [3:0]      idx;
    logic [15:0]     coef;
    logic [15:0]     smp;
  } filt_req_t;

  typedef struct packed {
    logic [iirdf_pkg::FILT_W-1:0] filtered;
    logic                         fault;
  } filt_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [iirdf_pkg::ORDER_W-1:0] cfg_filter_order = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [iirdf_pkg::REQ_W-1:0] in_req_type = '0;
  logic [iirdf_pkg::IDX_W-1:0] in_coef_index = '0;
  logic signed [15:0] in_coef_value = '0;
  logic signed [15:0] in_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [iirdf_pkg::FILT_W-1:0] out_filtered;
  logic out_divide_fault;

  iir_direct_form_filter DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_filter_order(cfg_filter_order),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_coef_index(in_coef_index), .in_coef_value(in_coef_value),
    .in_sample(in_sample), .out_valid(out_valid), .out_ready(out_ready),
    .out_filtered(out_filtered), .out_divide_fault(out_divide_fault)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [3:0]  order_q;
  logic [31:0] b_tab [0:NTAPS];
  logic [31:0] a_tab [0:NTAPS];
  logic [31:0] x_hist [0:NTAPS-1];
  logic [31:0] y_hist [0:NTAPS-1];

  filt_req_t pending_reqs[$];
  filt_out_t expected_outs[$];
  int errors = 0;
  int n_samples = 0;
  int n_faults = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;
  int order_seq[6] = '{0, 10, 15, 1, 7, 3};

  function automatic logic [31:0] div_trunc(logic [31:0] n, logic [31:0] d);
    logic [31:0] mn, md, q;
    mn = n[31] ? -n : n;
    md = d[31] ? -d : d;
    q = mn / md;
    return (n[31] != d[31]) ? -q : q;
  endfunction

  function automatic void predict_filter(filt_req_t r);
    logic [31:0] xv, acc, term;
    int taps;
    filt_out_t o;
    case (r.req)
      iirdf_pkg::REQ_NUM: if (r.idx <= NTAPS) b_tab[r.idx] = {{16{r.coef[15]}}, r.coef};
      iirdf_pkg::REQ_DEN: if (r.idx <= NTAPS) a_tab[r.idx] = {{16{r.coef[15]}}, r.coef};
      iirdf_pkg::REQ_FILTER: begin
        n_samples++;
        if (a_tab[0] == 0) begin
          n_faults++;
          o.filtered = '0;
          o.fault = 1'b1;
        end else begin
          xv = {{16{r.smp[15]}}, r.smp};
          taps = (order_q > NTAPS) ? NTAPS : order_q;
          acc = div_trunc(xv * b_tab[0], a_tab[0]);
          for (int k = 0; k < taps; k++) begin
            term = b_tab[k+1] * x_hist[k] - a_tab[k+1] * y_hist[k];
            acc += div_trunc(term, a_tab[0]);
          end
          for (int k = taps; k > 1; k--) begin
            x_hist[k-1] = x_hist[k-2];
            y_hist[k-1] = y_hist[k-2];
          end
          x_hist[0] = xv;
          y_hist[0] = acc;
          term = div_trunc(acc, iirdf_pkg::SCALE);
          o.filtered = term[iirdf_pkg::FILT_W-1:0];
          o.fault = 1'b0;
        end
        expected_outs.push_back(o);
      end
      default: ;
    endcase
  endfunction

  logic in_ready_seen = 1'b0;
  always @(posedge clk) in_ready_seen <= in_ready;

  // Driver: at most one nonblocking update of in_valid per falling edge.
  int drv_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready_seen) begin
        // Transfer happened at the last rising edge.
        predict_filter(pending_reqs.pop_front());
      end
      if (!(in_valid && !in_ready_seen)) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          if (!quiet && $urandom_range(0, 5) == 0) begin
            drv_gap = $urandom_range(0, 13);
            in_valid <= 1'b0;
          end else begin
            in_valid <= 1'b1;
            in_req_type <= pending_reqs[0].req;
            in_coef_index <= pending_reqs[0].idx;
            in_coef_value <= pending_reqs[0].coef;
            in_sample <= pending_reqs[0].smp;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern.
  int rcv_gap = 0;
  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_ready <= 1'b0;
    end else if (rcv_gap > 0) begin
      rcv_gap--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      rcv_gap = $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    filt_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_outs.size() == 0) begin
        $error("unexpected result: filtered=%0d fault=%0b", out_filtered, out_divide_fault);
        errors++;
      end else begin
        e = expected_outs.pop_front();
        if (out_filtered !== e.filtered) begin
          $error("filtered: expected %0d actual %0d", $signed(e.filtered), out_filtered);
          errors++;
        end
        if (out_divide_fault !== e.fault) begin
          $error("divide_fault: expected %0b actual %0b", e.fault, out_divide_fault);
          errors++;
        end
      end
    end
  end

  task automatic add_req(iirdf_pkg::req_t t, int idx, int coef, int smp);
    filt_req_t r;
    r.req = t;
    r.idx = idx[3:0];
    r.coef = coef[15:0];
    r.smp = smp[15:0];
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_outs.size() > 0)
      @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic set_order(int ord);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_filter_order <= ord[3:0];
    order_q = ord[3:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int rand_s16();
    return $urandom_range(0, 65535) - 32768;
  endfunction

  // Small stable-ish coefficient set with random content.
  task automatic random_program(int max_idx);
    add_req(iirdf_pkg::REQ_DEN, 0, $urandom_range(0, 1) ? $urandom_range(50, 400) :
            -$urandom_range(50, 400), 0);
    for (int k = 0; k <= max_idx; k++) begin
      add_req(iirdf_pkg::REQ_NUM, k, $urandom_range(0, 3) == 0 ? rand_s16() :
              $urandom_range(0, 200) - 100, 0);
      if (k > 0)
        add_req(iirdf_pkg::REQ_DEN, k, $urandom_range(0, 3) == 0 ? rand_s16() :
                $urandom_range(0, 100) - 50, 0);
    end
  endtask

  task automatic random_items(int count);
    int p;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, 99);
      if (p < 75)
        add_req(iirdf_pkg::REQ_FILTER, $urandom_range(0, 15), rand_s16(), rand_s16());
      else if (p < 85)
        add_req(iirdf_pkg::REQ_NUM, $urandom_range(0, 15), rand_s16(), rand_s16());
      else if (p < 95)
        add_req(iirdf_pkg::REQ_DEN, $urandom_range(1, 15), rand_s16(), rand_s16());
      else if (p < 98)
        add_req(iirdf_pkg::REQ_NONE, $urandom_range(0, 15), rand_s16(), rand_s16());
      else
        add_req(iirdf_pkg::REQ_DEN, 0, $urandom_range(0, 2) == 0 ? 0 : rand_s16(), 0);
    end
  endtask

  initial begin
    order_q = iirdf_pkg::ORDER_RST;
    for (int k = 0; k <= NTAPS; k++) begin
      b_tab[k] = '0;
      a_tab[k] = '0;
    end
    for (int k = 0; k < NTAPS; k++) begin
      x_hist[k] = '0;
      y_hist[k] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: fault with a0 at reset, extremes, ignored requests, overflow.
    add_req(iirdf_pkg::REQ_FILTER, 0, 0, 32767);
    add_req(iirdf_pkg::REQ_NONE, 5, 1234, -1);
    add_req(iirdf_pkg::REQ_NUM, 11, 999, 0);
    add_req(iirdf_pkg::REQ_DEN, 15, 999, 0);
    add_req(iirdf_pkg::REQ_DEN, 0, 100, 0);
    add_req(iirdf_pkg::REQ_NUM, 0, 32767, 0);
    add_req(iirdf_pkg::REQ_NUM, 1, -32768, 0);
    add_req(iirdf_pkg::REQ_DEN, 1, 32767, 0);
    add_req(iirdf_pkg::REQ_NUM, 10, -1, 0);
    add_req(iirdf_pkg::REQ_DEN, 10, -32768, 0);
    add_req(iirdf_pkg::REQ_FILTER, 0, 0, 32767);
    add_req(iirdf_pkg::REQ_FILTER, 0, 0, -32768);
    add_req(iirdf_pkg::REQ_FILTER, 0, 0, 0);
    add_req(iirdf_pkg::REQ_DEN, 0, -1, 0);
    add_req(iirdf_pkg::REQ_FILTER, 0, 0, -32768);
    add_req(iirdf_pkg::REQ_FILTER, 0, 0, 12345);
    add_req(iirdf_pkg::REQ_DEN, 0, 0, 0);
    add_req(iirdf_pkg::REQ_FILTER, 0, 0, 1);
    add_req(iirdf_pkg::REQ_DEN, 0, -32768, 0);
    add_req(iirdf_pkg::REQ_FILTER, 0, 0, -32768);
    drain();

    // Order sweep with the receiver held off once to back the block up.
    for (int ph = 0; ph < 6; ph++) begin
      set_order(order_seq[ph]);
      if (ph == 1) begin
        random_program(10);
        for (int i = 0; i < 6; i++) add_req(iirdf_pkg::REQ_FILTER, 0, 0, rand_s16());
        hold_off = 1'b1;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
      end
      random_program(10);
      random_items(75);
      if (ph == 5) quiet = 1'b1;
      drain();
    end

    $display("Covered %0d samples (%0d divide faults) across filter orders 0..15.",
             n_samples, n_faults);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> iir_direct_form_filter.f
design/iirdf_pkg.sv
design/iirdf_ram.sv
design/iirdf_div.sv
design/iir_direct_form_filter.sv
dv/tb_iir_direct_form_filter.sv
